>>> rtl/tvcs_pkg.sv
`timescale 1ns / 1ps
// tvcs_pkg: widths, register map, reset values and payload types of the
// torque vectoring current split. No dependencies.
package tvcs_pkg;

   localparam int TOTAL_W  = 16;
   localparam int YAW_W    = 20;
   localparam int LIMIT_W  = 16;
   localparam int CUR_W    = 16;
   localparam int TRACK_W  = 12;
   localparam int RADIUS_W = 10;
   localparam int GEAR_W   = 16;
   localparam int KT_W     = 16;
   localparam int MAXI_W   = 15;

   localparam int DATA_W   = 32;
   localparam int ADDR_W   = 5;

   localparam int MAG_W    = YAW_W;
   localparam int MAGR_W   = MAG_W + RADIUS_W;
   localparam int FRAC_SH  = 20;
   localparam int NUM_W    = MAGR_W + FRAC_SH;
   localparam int TK_W     = TRACK_W + KT_W;
   localparam int DEN_W    = TK_W + GEAR_W;
   localparam int Q_W      = 16;
   localparam int SIDE_W   = MAXI_W + 1;
   localparam int VAL_W    = 20;

   localparam logic [TRACK_W-1:0]  TRACK_RESET  = TRACK_W'(1200);
   localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(250);
   localparam logic [GEAR_W-1:0]   GEAR_RESET   = GEAR_W'(2560);
   localparam logic [KT_W-1:0]     KT_RESET     = KT_W'(4096);
   localparam logic [MAXI_W-1:0]   MAXI_RESET   = MAXI_W'(3200);

   localparam logic [Q_W-1:0] Q_POS_CAP = Q_W'(32767);
   localparam logic [Q_W-1:0] Q_NEG_CAP = Q_W'(32768);
   localparam logic signed [VAL_W-1:0] DIFF_HI = VAL_W'(32767);
   localparam logic signed [VAL_W-1:0] DIFF_LO = -VAL_W'(32768);

   typedef enum logic [2:0] {
      REG_TRACK  = 3'd0,
      REG_RADIUS = 3'd1,
      REG_GEAR   = 3'd2,
      REG_KT     = 3'd3,
      REG_MAXI   = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic [TRACK_W-1:0]  track_width;
      logic [RADIUS_W-1:0] wheel_radius;
      logic [GEAR_W-1:0]   reduction_q8;
      logic [KT_W-1:0]     torque_constant;
      logic [MAXI_W-1:0]   motor_current_limit;
   } cfg_type;

   // per-item values that ride alongside the divider
   typedef struct packed {
      logic                      zero;
      logic                      neg;
      logic signed [TOTAL_W-1:0] total;
      logic [SIDE_W-1:0]         max_l;
      logic [SIDE_W-1:0]         max_r;
   } side_type;

   typedef struct packed {
      side_type          side;
      logic [NUM_W-1:0]  rem;
      logic [DEN_W-1:0]  den;
      logic [Q_W-1:0]    q;
      logic              sat;
   } div_type;

   function automatic logic signed [VAL_W-1:0] lim(
      input logic signed [VAL_W-1:0] v,
      input logic signed [VAL_W-1:0] lo,
      input logic signed [VAL_W-1:0] hi
   );
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic logic signed [VAL_W-1:0] side_val(input logic [SIDE_W-1:0] m);
      return $signed({{(VAL_W-SIDE_W){1'b0}}, m});
   endfunction

   function automatic logic signed [VAL_W-1:0] total_val(
      input logic signed [TOTAL_W-1:0] t
   );
      return $signed({{(VAL_W-TOTAL_W){t[TOTAL_W-1]}}, t});
   endfunction

endpackage

>>> rtl/tvcs_csr.sv
`timescale 1ns / 1ps
// tvcs_csr: APB-style register file for the geometry and motor settings.
// Depends on tvcs_pkg.
module tvcs_csr import tvcs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready,
   output cfg_type           cfg
);

   cfg_type       cfg_ff;
   reg_index_type idx;
   logic          wr;

   assign pready = 1'b1;
   assign idx    = reg_index_type'(paddr[ADDR_W-1:2]);
   assign wr     = psel & penable & pwrite & pready;
   assign cfg    = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.track_width         <= TRACK_RESET;
         cfg_ff.wheel_radius        <= RADIUS_RESET;
         cfg_ff.reduction_q8        <= GEAR_RESET;
         cfg_ff.torque_constant     <= KT_RESET;
         cfg_ff.motor_current_limit <= MAXI_RESET;
      end else if (wr) begin
         case (idx)
            REG_TRACK:  cfg_ff.track_width         <= pwdata[TRACK_W-1:0];
            REG_RADIUS: cfg_ff.wheel_radius        <= pwdata[RADIUS_W-1:0];
            REG_GEAR:   cfg_ff.reduction_q8        <= pwdata[GEAR_W-1:0];
            REG_KT:     cfg_ff.torque_constant     <= pwdata[KT_W-1:0];
            REG_MAXI:   cfg_ff.motor_current_limit <= pwdata[MAXI_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_TRACK:  prdata = DATA_W'(cfg_ff.track_width);
         REG_RADIUS: prdata = DATA_W'(cfg_ff.wheel_radius);
         REG_GEAR:   prdata = DATA_W'(cfg_ff.reduction_q8);
         REG_KT:     prdata = DATA_W'(cfg_ff.torque_constant);
         REG_MAXI:   prdata = DATA_W'(cfg_ff.motor_current_limit);
         default:    prdata = '0;
      endcase
   end

endmodule

>>> rtl/tvcs_front.sv
`timescale 1ns / 1ps
// tvcs_front: three stages that clamp the side limits and build the
// divider's numerator, denominator and overflow flag. Depends on tvcs_pkg.
module tvcs_front import tvcs_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  cfg_type                   cfg,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic signed [TOTAL_W-1:0] total_current,
   input  logic signed [YAW_W-1:0]   yaw_moment,
   input  logic signed [LIMIT_W-1:0] limit_left,
   input  logic signed [LIMIT_W-1:0] limit_right,
   output logic                      out_valid,
   input  logic                      out_ready,
   output div_type                   out_data
);

   logic v1_ff, v2_ff, v3_ff;
   logic en1, en2, en3;

   side_type           s1_ff, s2_ff;
   logic [MAGR_W-1:0]  magr1_ff;
   logic [TK_W-1:0]    tk1_ff;
   logic [NUM_W-1:0]   num2_ff;
   logic [DEN_W-1:0]   den2_ff;
   div_type            d3_ff;

   side_type           s1_in;
   logic [MAG_W-1:0]   mag;
   logic [MAXI_W-1:0]  cl_l, cl_r;
   logic signed [LIMIT_W-1:0] mx_s;
   div_type            d3_in;

   assign en3      = ~v3_ff | out_ready;
   assign en2      = ~v2_ff | en3;
   assign en1      = ~v1_ff | en2;
   assign in_ready = en1;
   assign out_valid = v3_ff;
   assign out_data  = d3_ff;

   // stage 1: limits, magnitude products
   always_comb begin
      mx_s = $signed({1'b0, cfg.motor_current_limit});
      if (limit_left < 0)
         cl_l = '0;
      else if (limit_left > mx_s)
         cl_l = cfg.motor_current_limit;
      else
         cl_l = limit_left[MAXI_W-1:0];
      if (limit_right < 0)
         cl_r = '0;
      else if (limit_right > mx_s)
         cl_r = cfg.motor_current_limit;
      else
         cl_r = limit_right[MAXI_W-1:0];
      mag = yaw_moment[YAW_W-1] ? $unsigned(-yaw_moment) : $unsigned(yaw_moment);
      s1_in.zero  = (total_current == '0) || (cfg.track_width == '0) ||
                    (cfg.wheel_radius == '0) || (cfg.reduction_q8 == '0) ||
                    (cfg.torque_constant == '0) || (cfg.motor_current_limit == '0);
      s1_in.neg   = yaw_moment[YAW_W-1];
      s1_in.total = total_current;
      s1_in.max_l = {cl_l, 1'b0};
      s1_in.max_r = {cl_r, 1'b0};
   end

   // stage 3: quotient would not fit in Q_W bits
   always_comb begin
      d3_in.side = s2_ff;
      d3_in.rem  = num2_ff;
      d3_in.den  = den2_ff;
      d3_in.q    = '0;
      d3_in.sat  = DEN_W'(num2_ff[NUM_W-1:Q_W]) >= den2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= in_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_ff    <= s1_in;
         magr1_ff <= MAGR_W'(mag) * MAGR_W'(cfg.wheel_radius);
         tk1_ff   <= TK_W'(cfg.track_width) * TK_W'(cfg.torque_constant);
      end
      if (en2) begin
         s2_ff   <= s1_ff;
         num2_ff <= {magr1_ff, {FRAC_SH{1'b0}}};
         den2_ff <= DEN_W'(tk1_ff) * DEN_W'(cfg.reduction_q8);
      end
      if (en3) begin
         d3_ff <= d3_in;
      end
   end

endmodule

>>> rtl/tvcs_divider.sv
`timescale 1ns / 1ps
// tvcs_divider: restoring divider, one quotient bit per pipeline stage.
// Depends on tvcs_pkg.
module tvcs_divider import tvcs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  div_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output div_type out_data
);

   logic    v_ff [Q_W];
   div_type d_ff [Q_W];
   logic    en   [Q_W];

   assign in_ready  = en[0];
   assign out_valid = v_ff[Q_W-1];
   assign out_data  = d_ff[Q_W-1];

   for (genvar k = 0; k < Q_W; k++) begin : g_step
      localparam int BIT = Q_W - 1 - k;
      logic    v_src;
      div_type d_src;
      div_type d_in;
      logic [DEN_W+Q_W-1:0] sh;
      logic [DEN_W+Q_W-1:0] rx;

      if (k == 0) begin : g_first
         assign v_src = in_valid;
         assign d_src = in_data;
      end else begin : g_next
         assign v_src = v_ff[k-1];
         assign d_src = d_ff[k-1];
      end

      if (k == Q_W - 1) begin : g_last
         assign en[k] = ~v_ff[k] | out_ready;
      end else begin : g_mid
         assign en[k] = ~v_ff[k] | en[k+1];
      end

      always_comb begin
         sh   = (DEN_W+Q_W)'(d_src.den) << BIT;
         rx   = (DEN_W+Q_W)'(d_src.rem);
         d_in = d_src;
         if (rx >= sh) begin
            d_in.rem    = d_src.rem - sh[NUM_W-1:0];
            d_in.q[BIT] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en[k]) begin
            v_ff[k] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en[k]) begin
            d_ff[k] <= d_in;
         end
      end
   end

endmodule

>>> rtl/tvcs_back.sv
`timescale 1ns / 1ps
// tvcs_back: three stages that saturate and clamp the difference, place the
// base current and form the side currents. Depends on tvcs_pkg.
module tvcs_back import tvcs_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  div_type                 in_data,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic signed [CUR_W-1:0] current_left,
   output logic signed [CUR_W-1:0] current_right
);

   logic v1_ff, v2_ff, v3_ff;
   logic en1, en2, en3;

   side_type                 s1_ff, s2_ff;
   logic signed [VAL_W-1:0]  diff1_ff, diff2_ff, base2_ff;
   logic signed [CUR_W-1:0]  cl3_ff, cr3_ff;

   logic signed [VAL_W-1:0]  qv, dq, dd, lo, hi, t1, half, diff1_in;
   logic signed [VAL_W-1:0]  ml2, mr2, lo_l2, hi_l2, lo_r2, hi_r2, t2;
   logic signed [VAL_W-1:0]  a, b, c, e, base_lo, base_hi, base2_in;
   logic signed [VAL_W-1:0]  ml3, mr3, lo_l3, hi_l3, lo_r3, hi_r3, cl, cr, hl, hr;
   logic                     pos1, pos2, pos3;

   assign en3       = ~v3_ff | out_ready;
   assign en2       = ~v2_ff | en3;
   assign en1       = ~v1_ff | en2;
   assign in_ready  = en1;
   assign out_valid = v3_ff;
   assign current_left  = cl3_ff;
   assign current_right = cr3_ff;

   // stage 1: saturate quotient, clamp by side limits and half total
   always_comb begin
      qv = $signed({{(VAL_W-Q_W){1'b0}}, in_data.q});
      if (in_data.side.neg)
         dq = (in_data.sat || in_data.q > Q_NEG_CAP) ? DIFF_LO : -qv;
      else
         dq = (in_data.sat || in_data.q > Q_POS_CAP) ? DIFF_HI : qv;
      dd   = dq <<< 1;
      pos1 = ~in_data.side.total[TOTAL_W-1];
      lo   = pos1 ? -side_val(in_data.side.max_l) : -side_val(in_data.side.max_r);
      hi   = pos1 ? side_val(in_data.side.max_r) : side_val(in_data.side.max_l);
      t1   = total_val(in_data.side.total);
      half = (t1 < 0) ? -t1 : t1;
      diff1_in = lim(lim(dd, lo, hi), -half, half);
   end

   // stage 2: base window
   always_comb begin
      pos2  = ~s1_ff.total[TOTAL_W-1];
      ml2   = side_val(s1_ff.max_l);
      mr2   = side_val(s1_ff.max_r);
      lo_l2 = pos2 ? '0 : -ml2;
      hi_l2 = pos2 ? ml2 : '0;
      lo_r2 = pos2 ? '0 : -mr2;
      hi_r2 = pos2 ? mr2 : '0;
      t2    = total_val(s1_ff.total);
      a     = lo_l2 + diff1_ff;
      b     = lo_r2 - diff1_ff;
      c     = hi_l2 + diff1_ff;
      e     = hi_r2 - diff1_ff;
      base_lo  = (a > b) ? a : b;
      base_hi  = (c < e) ? c : e;
      base2_in = lim(t2, base_lo, base_hi);
   end

   // stage 3: side currents, halved toward zero
   always_comb begin
      pos3  = ~s2_ff.total[TOTAL_W-1];
      ml3   = side_val(s2_ff.max_l);
      mr3   = side_val(s2_ff.max_r);
      lo_l3 = pos3 ? '0 : -ml3;
      hi_l3 = pos3 ? ml3 : '0;
      lo_r3 = pos3 ? '0 : -mr3;
      hi_r3 = pos3 ? mr3 : '0;
      cl    = lim(base2_ff - diff2_ff, lo_l3, hi_l3);
      cr    = lim(base2_ff + diff2_ff, lo_r3, hi_r3);
      hl    = (cl + VAL_W'(cl[VAL_W-1])) >>> 1;
      hr    = (cr + VAL_W'(cr[VAL_W-1])) >>> 1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= in_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_ff    <= in_data.side;
         diff1_ff <= diff1_in;
      end
      if (en2) begin
         s2_ff    <= s1_ff;
         diff2_ff <= diff1_ff;
         base2_ff <= base2_in;
      end
      if (en3) begin
         cl3_ff <= s2_ff.zero ? '0 : hl[CUR_W-1:0];
         cr3_ff <= s2_ff.zero ? '0 : hr[CUR_W-1:0];
      end
   end

endmodule

>>> rtl/torque_vector_current_split_unit.sv
`timescale 1ns / 1ps
// torque_vector_current_split_unit: top level, register file and pipeline.
// Depends on tvcs_pkg, tvcs_csr, tvcs_front, tvcs_divider, tvcs_back.
//
//   channel   handshake              payload
//   req       req_valid/req_ready    total_current, yaw_moment, limit_left, limit_right
//   rsp       rsp_valid/rsp_ready    current_left, current_right
//   csr       psel/penable/pready    paddr, pwrite, pwdata, prdata
//
// one item per cycle while rsp_ready keeps taking results; 3 front stages,
// 16 divider stages at one quotient bit each, 3 back stages
// reset clears only the stage valid bits and loads the register defaults
// each stage holds while its successor is full and stalled; empty stages
// keep filling behind a waiting result
module torque_vector_current_split_unit import tvcs_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [TOTAL_W-1:0] req_total_current,
   input  logic signed [YAW_W-1:0]   req_yaw_moment,
   input  logic signed [LIMIT_W-1:0] req_limit_left,
   input  logic signed [LIMIT_W-1:0] req_limit_right,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [CUR_W-1:0]   rsp_current_left,
   output logic signed [CUR_W-1:0]   rsp_current_right,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [ADDR_W-1:0]         paddr,
   input  logic [DATA_W-1:0]         pwdata,
   output logic [DATA_W-1:0]         prdata,
   output logic                      pready
);

   cfg_type cfg;
   logic    f_valid, f_ready, d_valid, d_ready;
   div_type f_data, d_data;

   tvcs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   tvcs_front u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .in_valid      (req_valid),
      .in_ready      (req_ready),
      .total_current (req_total_current),
      .yaw_moment    (req_yaw_moment),
      .limit_left    (req_limit_left),
      .limit_right   (req_limit_right),
      .out_valid     (f_valid),
      .out_ready     (f_ready),
      .out_data      (f_data)
   );

   tvcs_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_data   (f_data),
      .out_valid (d_valid),
      .out_ready (d_ready),
      .out_data  (d_data)
   );

   tvcs_back u_back (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (d_valid),
      .in_ready      (d_ready),
      .in_data       (d_data),
      .out_valid     (rsp_valid),
      .out_ready     (rsp_ready),
      .current_left  (rsp_current_left),
      .current_right (rsp_current_right)
   );

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// tb: self-checking testbench for torque_vector_current_split_unit. A scoreboard class predicts
// each item's left and right currents from its own copy of the registers and checks every result.
// Depends on tvcs_pkg and the unit's RTL.
module tb;
   import tvcs_pkg::*;

   localparam int LATENCY      = 22;
   localparam int HOLD_CYCLES  = 160;
   localparam int QUIET_LIMIT  = 4000;
   localparam int REG_SLOTS    = 1 << (ADDR_W - 2);

   typedef struct {
      logic signed [CUR_W-1:0] left;
      logic signed [CUR_W-1:0] right;
   } currents_type;

   typedef enum {READY_ALWAYS, READY_RANDOM, READY_PATTERN} ready_mode_type;

   class split_scoreboard;
      cfg_type      cfg;
      currents_type expected_currents[$];
      int           failures;

      function new();
         cfg.track_width         = TRACK_RESET;
         cfg.wheel_radius        = RADIUS_RESET;
         cfg.reduction_q8        = GEAR_RESET;
         cfg.torque_constant     = KT_RESET;
         cfg.motor_current_limit = MAXI_RESET;
         failures = 0;
      endfunction

      function void report(string msg);
         failures++;
         if (failures <= 10) begin
            $display("%0t mismatch: %s", $time, msg);
         end
      endfunction

      function int pending();
         return expected_currents.size();
      endfunction

      static function longint clamp(longint v, longint lo, longint hi);
         return (v < lo) ? lo : ((v > hi) ? hi : v);
      endfunction

      function currents_type predict_currents(logic signed [TOTAL_W-1:0] total,
                                              logic signed [YAW_W-1:0]   yaw,
                                              logic signed [LIMIT_W-1:0] limit_l,
                                              logic signed [LIMIT_W-1:0] limit_r);
         currents_type r;
         longint       t, y, mx, max_l, max_r, diff, lo_l, hi_l, lo_r, hi_r;
         longint       mag_total, base_lo, base_hi, base, cl, cr;
         longint unsigned mag, num, den, q;
         r.left  = '0;
         r.right = '0;
         t = total;
         y = yaw;
         if (t == 0 || cfg.track_width == 0 || cfg.wheel_radius == 0 ||
             cfg.reduction_q8 == 0 ||
             cfg.torque_constant == 0 || cfg.motor_current_limit == 0) begin
            return r;
         end
         mx = cfg.motor_current_limit;
         // side limits kept at 1/32 A
         max_l = 2 * clamp(limit_l, 0, mx);
         max_r = 2 * clamp(limit_r, 0, mx);

         mag = (y < 0) ? -y : y;
         num = mag * cfg.wheel_radius;
         num = num << FRAC_SH;
         den = cfg.track_width;
         den = den * cfg.torque_constant;
         den = den * cfg.reduction_q8;
         q = num / den;
         if (y < 0) begin
            diff = (q > 64'd32768) ? -32768 : -longint'(q);
         end else begin
            diff = (q > 64'd32767) ? 32767 : longint'(q);
         end
         diff = diff * 2;

         if (t > 0) begin
            lo_l = 0;
            lo_r = 0;
            hi_l = max_l;
            hi_r = max_r;
            diff = clamp(diff, -max_l, max_r);
         end else begin
            lo_l = -max_l;
            hi_l = 0;
            lo_r = -max_r;
            hi_r = 0;
            diff = clamp(diff, -max_r, max_l);
         end
         mag_total = (t < 0) ? -t : t;
         diff = clamp(diff, -mag_total, mag_total);

         base_lo = (lo_l + diff > lo_r - diff) ? lo_l + diff : lo_r - diff;
         base_hi = (hi_l + diff < hi_r - diff) ? hi_l + diff : hi_r - diff;
         base = clamp(t, base_lo, base_hi);

         cl = clamp(base - diff, lo_l, hi_l) / 2;
         cr = clamp(base + diff, lo_r, hi_r) / 2;
         r.left  = CUR_W'(cl);
         r.right = CUR_W'(cr);
         return r;
      endfunction

      function void note_input(logic signed [TOTAL_W-1:0] total, logic signed [YAW_W-1:0] yaw,
                               logic signed [LIMIT_W-1:0] limit_l,
                               logic signed [LIMIT_W-1:0] limit_r);
         expected_currents.push_back(predict_currents(total, yaw, limit_l, limit_r));
      endfunction

      function void check_result(logic signed [CUR_W-1:0] left, logic signed [CUR_W-1:0] right);
         currents_type want;
         if (expected_currents.size() == 0) begin
            report($sformatf("unexpected result left %0d right %0d", left, right));
            return;
         end
         want = expected_currents.pop_front();
         if (left !== want.left) begin
            report($sformatf("current_left expected %0d got %0d", want.left, left));
         end
         if (right !== want.right) begin
            report($sformatf("current_right expected %0d got %0d", want.right, right));
         end
      endfunction

      function void write_reg(logic [ADDR_W-3:0] idx, logic [DATA_W-1:0] value);
         case (reg_index_type'(idx))
            REG_TRACK:  cfg.track_width         = value[TRACK_W-1:0];
            REG_RADIUS: cfg.wheel_radius        = value[RADIUS_W-1:0];
            REG_GEAR:   cfg.reduction_q8        = value[GEAR_W-1:0];
            REG_KT:     cfg.torque_constant     = value[KT_W-1:0];
            REG_MAXI:   cfg.motor_current_limit = value[MAXI_W-1:0];
            default: ;
         endcase
      endfunction

      function void check_register(logic [ADDR_W-3:0] idx, logic [DATA_W-1:0] got);
         logic [DATA_W-1:0] want;
         bit                known;
         known = 1'b1;
         want  = '0;
         case (reg_index_type'(idx))
            REG_TRACK:  want = DATA_W'(cfg.track_width);
            REG_RADIUS: want = DATA_W'(cfg.wheel_radius);
            REG_GEAR:   want = DATA_W'(cfg.reduction_q8);
            REG_KT:     want = DATA_W'(cfg.torque_constant);
            REG_MAXI:   want = DATA_W'(cfg.motor_current_limit);
            default:    known = 1'b0;
         endcase
         if (known && got !== want) begin
            report($sformatf("register %0d read expected %0d got %0d", idx, want, got));
         end
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic signed [TOTAL_W-1:0] req_total_current;
   logic signed [YAW_W-1:0]   req_yaw_moment;
   logic signed [LIMIT_W-1:0] req_limit_left;
   logic signed [LIMIT_W-1:0] req_limit_right;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic signed [CUR_W-1:0]   rsp_current_left;
   logic signed [CUR_W-1:0]   rsp_current_right;
   logic                      psel;
   logic                      penable;
   logic                      pwrite;
   logic [ADDR_W-1:0]         paddr;
   logic [DATA_W-1:0]         pwdata;
   logic [DATA_W-1:0]         prdata;
   logic                      pready;

   split_scoreboard sb;
   int              burst_left;
   bit              gaps_on;
   bit              hold_rsp;
   int              quiet_cycles = 0;

   torque_vector_current_split_unit u_dut (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            sb.note_input(req_total_current, req_yaw_moment, req_limit_left, req_limit_right);
         end
         if (rsp_valid && rsp_ready) begin
            sb.check_result(rsp_current_left, rsp_current_right);
         end
         if (psel && penable && pready) begin
            if (pwrite) begin
               sb.write_reg(paddr[ADDR_W-1:2], pwdata);
            end else begin
               sb.check_register(paddr[ADDR_W-1:2], prdata);
            end
         end
      end
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("[torque_vector_current_split_unit] ERROR");
      $finish;
   end

   // result side: changing stall patterns, plus one long hold-off on request
   initial begin
      ready_mode_type mode;
      int             mode_left;
      logic [15:0]    pattern;
      mode      = READY_ALWAYS;
      mode_left = 0;
      pattern   = 16'hffff;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode      = ready_mode_type'($urandom_range(0, 2));
               mode_left = $urandom_range(20, 300);
               pattern   = 16'($urandom) | 16'd1;
            end
            mode_left--;
            case (mode)
               READY_ALWAYS: rsp_ready <= 1'b1;
               READY_RANDOM: rsp_ready <= ($urandom_range(0, 3) != 0);
               default: begin
                  rsp_ready <= pattern[0];
                  pattern = {pattern[0], pattern[15:1]};
               end
            endcase
         end
      end
   end

   task automatic send_item(input logic signed [TOTAL_W-1:0] total,
                            input logic signed [YAW_W-1:0]   yaw,
                            input logic signed [LIMIT_W-1:0] limit_l,
                            input logic signed [LIMIT_W-1:0] limit_r);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = gaps_on ? $urandom_range(0, 7) : 0;
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid         <= 1'b1;
      req_total_current <= total;
      req_yaw_moment    <= yaw;
      req_limit_left    <= limit_l;
      req_limit_right   <= limit_r;
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic logic signed [LIMIT_W-1:0] pick_limit();
      case ($urandom_range(0, 7))
         0:       return LIMIT_W'($urandom);
         1:       return -LIMIT_W'($urandom_range(1, 32768));
         2:       return '0;
         3:       return LIMIT_W'(32767);
         default: return LIMIT_W'($urandom_range(0, 4000));
      endcase
   endfunction

   task automatic send_random_item();
      logic signed [TOTAL_W-1:0] total;
      logic signed [YAW_W-1:0]   yaw;
      case ($urandom_range(0, 9))
         0: total = '0;
         1: total = TOTAL_W'($urandom);
         2: begin
            case ($urandom_range(0, 3))
               0:       total = TOTAL_W'(32767);
               1:       total = TOTAL_W'(-32768);
               2:       total = TOTAL_W'(1);
               default: total = TOTAL_W'(-1);
            endcase
         end
         default: begin
            total = TOTAL_W'($urandom_range(1, 4000));
            if ($urandom_range(0, 1)) total = -total;
         end
      endcase
      case ($urandom_range(0, 7))
         0: yaw = YAW_W'($urandom);
         1: yaw = $urandom_range(0, 1) ? YAW_W'(524287) : YAW_W'(-524288);
         2: yaw = '0;
         default: begin
            yaw = YAW_W'($urandom_range(0, 150000));
            if ($urandom_range(0, 1)) yaw = -yaw;
         end
      endcase
      send_item(total, yaw, pick_limit(), pick_limit());
   endtask

   task automatic apb_access(input logic wr, input int idx, input logic [DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= ADDR_W'(idx * 4);
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [DATA_W-1:0] with_noise(input int unsigned value, input int width);
      logic [DATA_W-1:0] mask;
      mask = (DATA_W'(1) << width) - DATA_W'(1);
      return (DATA_W'($urandom) & ~mask) | (DATA_W'(value) & mask);
   endfunction

   task automatic read_all_registers();
      for (int i = REG_TRACK; i <= REG_MAXI; i++) begin
         apb_access(1'b0, i, '0);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   initial begin
      int unsigned track, radius, gear, kt, maxi;
      sb = new();
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_total_current <= '0;
      req_yaw_moment    <= '0;
      req_limit_left    <= '0;
      req_limit_right   <= '0;
      psel              <= 1'b0;
      penable           <= 1'b0;
      pwrite            <= 1'b0;
      paddr             <= '0;
      pwdata            <= '0;
      burst_left = 0;
      gaps_on    = 1'b1;
      hold_rsp   = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      read_all_registers();

      // zero total, field extremes, regen, empty base window, negative limits
      send_item(0, 1000, 3200, 3200);
      send_item(32767, 0, 32767, 32767);
      send_item(-32768, 0, 32767, 32767);
      send_item(1, 524287, 3200, 3200);
      send_item(-1, -524288, 3200, 3200);
      send_item(2000, 524287, 3200, 100);
      send_item(2000, -524288, 50, 3200);
      send_item(-2000, 524287, 100, 3200);
      send_item(-2000, -300000, 3200, 0);
      send_item(1000, 20000, -32768, -5);
      send_item(1000, -20000, -1, 32767);
      send_item(5000, 48000, 3200, 3200);
      send_item(-5000, -1, 3200, 3200);
      send_item(3, 1, 0, 0);
      send_item(-3, 97, 1, 1);
      send_item(6400, -48, 3200, 3200);
      send_item(-32768, -524288, -32768, -32768);
      send_item(32767, 524287, 32767, 32767);
      drain();

      for (int phase = 0; phase < 12; phase++) begin
         if (phase != 0) begin
            track  = $urandom_range(800, 2000);
            radius = $urandom_range(200, 400);
            gear   = $urandom_range(1280, 5120);
            kt     = $urandom_range(1024, 8192);
            maxi   = $urandom_range(1000, 32767);
            case (phase)
               2: begin
                  track  = (1 << TRACK_W) - 1;
                  radius = (1 << RADIUS_W) - 1;
                  gear   = (1 << GEAR_W) - 1;
                  kt     = (1 << KT_W) - 1;
                  maxi   = (1 << MAXI_W) - 1;
               end
               3: begin
                  track  = 1;
                  radius = 1;
                  gear   = 1;
                  kt     = 1;
                  maxi   = 1;
               end
               4: track  = 0;
               5: radius = 0;
               6: gear   = 0;
               7: kt     = 0;
               8: maxi   = 0;
               9: begin
                  track  = $urandom_range(0, (1 << TRACK_W) - 1);
                  radius = $urandom_range(0, (1 << RADIUS_W) - 1);
                  gear   = $urandom_range(0, (1 << GEAR_W) - 1);
                  kt     = $urandom_range(0, (1 << KT_W) - 1);
                  maxi   = $urandom_range(0, (1 << MAXI_W) - 1);
               end
               10: maxi = $urandom_range(1, 50);
               default: ;
            endcase
            apb_access(1'b1, REG_TRACK, with_noise(track, TRACK_W));
            apb_access(1'b1, REG_RADIUS, with_noise(radius, RADIUS_W));
            apb_access(1'b1, REG_GEAR, with_noise(gear, GEAR_W));
            apb_access(1'b1, REG_KT, with_noise(kt, KT_W));
            apb_access(1'b1, REG_MAXI, with_noise(maxi, MAXI_W));
            if (phase == 11) begin
               for (int i = REG_MAXI + 1; i < REG_SLOTS; i++) begin
                  apb_access(1'b1, i, $urandom);
               end
            end
            read_all_registers();
         end

         if (phase == 1) begin
            // result side held off while items keep coming
            hold_rsp = 1'b1;
            gaps_on  = 1'b0;
            repeat (80) send_random_item();
         end
         gaps_on = (phase % 3 != 2);
         repeat ((phase >= 4 && phase <= 8) ? 30 : 170) send_random_item();
         drain();
      end

      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("[torque_vector_current_split_unit] OK");
      end else begin
         $display("[torque_vector_current_split_unit] ERROR");
      end
      $finish;
   end
endmodule
